[rtl/shp3_pkg.sv]
// Shared types and constants for the 3x3 sharpening block.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package shp3_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 7'd64;

  // Operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Tap sequence of a compute, one frame store read each
  typedef logic [2:0] tap_t;
  localparam tap_t TAP_CENTRE = 3'd0;
  localparam tap_t TAP_LEFT   = 3'd1;
  localparam tap_t TAP_RIGHT  = 3'd2;
  localparam tap_t TAP_UP     = 3'd3;
  localparam tap_t TAP_DOWN   = 3'd4;

  // Last count values of the sequencer
  localparam logic [2:0] LAST_MOD_STEP = 3'd5;  // six remainder steps
  localparam logic [2:0] LAST_TAP      = 3'd4;  // five taps

  typedef struct packed {
    logic       operation;
    logic [5:0] column;
    logic [5:0] row;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
  } out_item_t;

  typedef struct packed {
    logic capture;   // take the input transfer
    logic mod_step;  // one remainder step on column and row
    logic write_en;  // store the held pixel
    logic rd_en;     // read one tap
    tap_t tap;       // which tap to read
    logic emit;      // load the output register
  } cmd_t;

  typedef struct packed {
    logic is_compute;  // held item asks for a result
    logic out_free;    // output register can take a result this cycle
  } stat_t;

endpackage

[rtl/shp3_ctrl.sv]
// Sequencer of the 3x3 sharpening block: steps each item through its phases.
// Depends on shp3_pkg; drives the datapath through cmd_t, reads stat_t.
`timescale 1ns / 1ps

module shp3_ctrl
  import shp3_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD   = 6'b000010,
    S_WRITE = 6'b000100,
    S_READ  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [2:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cnt_next    = '0;
          state_next  = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (cnt == LAST_MOD_STEP) begin
          cnt_next   = '0;
          state_next = stat.is_compute ? S_READ : S_WRITE;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      S_WRITE: begin
        cmd.write_en = 1'b1;
        state_next   = S_IDLE;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        cmd.tap   = cnt;
        if (cnt == LAST_TAP) begin
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      S_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result loaded while output register busy");

  a_capture_mod: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_MOD) && (cnt == 3'd0))
    else $error("accepted item did not start remainder steps");

  a_all_taps: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> ($past(state) == S_READ) && ($past(cnt) == LAST_TAP))
    else $error("compute drained before all taps were read");

  a_write_load: assert property (@(posedge clk) disable iff (rst)
    cmd.write_en |-> !stat.is_compute)
    else $error("frame store written for a compute item");

endmodule

[rtl/shp3_datapath.sv]
// Datapath of the 3x3 sharpening block: size registers, remainder unit,
// frame store, tap accumulators and output register. Depends on shp3_pkg.
`timescale 1ns / 1ps

module shp3_datapath
  import shp3_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [6:0] width_reg, height_reg;
  logic [6:0] w_eff, h_eff;

  logic        op_hold;
  logic [23:0] pix_hold;
  logic [5:0]  dvd_c, dvd_r;
  logic [6:0]  rem_c, rem_r;
  logic [7:0]  trial_c, trial_r;

  logic [6:0]  col_left, col_right, row_up, row_down;
  logic [6:0]  sel_col, sel_row;
  logic [AW-1:0] addr;

  logic [23:0] mem [DEPTH];
  logic [23:0] rd_data;
  logic        acc_en, acc_first;
  logic signed [11:0] acc [3];

  function automatic logic [7:0] clamp8(input logic signed [11:0] v);
    if (v < 0) return 8'd0;
    if (v > 12'sd255) return 8'd255;
    return v[7:0];
  endfunction

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= SIZE_RESET;
      height_reg <= SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH:  width_reg  <= cfg_data;
        REG_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (width_reg == 7'd0) ? 7'd1 :
                 (width_reg > MAX_WIDTH) ? 7'(MAX_WIDTH) : width_reg;
  assign h_eff = (height_reg == 7'd0) ? 7'd1 :
                 (height_reg > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : height_reg;

  // Restoring remainder, one dividend bit per step
  assign trial_c = {rem_c, dvd_c[5]};
  assign trial_r = {rem_r, dvd_r[5]};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_hold  <= in_data.operation;
      pix_hold <= {in_data.red_in, in_data.green_in, in_data.blue_in};
      dvd_c    <= in_data.column;
      dvd_r    <= in_data.row;
      rem_c    <= '0;
      rem_r    <= '0;
    end else if (cmd.mod_step) begin
      dvd_c <= {dvd_c[4:0], 1'b0};
      dvd_r <= {dvd_r[4:0], 1'b0};
      rem_c <= (trial_c >= {1'b0, w_eff}) ? 7'(trial_c - {1'b0, w_eff}) : trial_c[6:0];
      rem_r <= (trial_r >= {1'b0, h_eff}) ? 7'(trial_r - {1'b0, h_eff}) : trial_r[6:0];
    end
  end

  // Wrapped neighbour coordinates
  assign col_left  = (rem_c == 7'd0) ? w_eff - 7'd1 : rem_c - 7'd1;
  assign col_right = (rem_c + 7'd1 == w_eff) ? 7'd0 : rem_c + 7'd1;
  assign row_up    = (rem_r == 7'd0) ? h_eff - 7'd1 : rem_r - 7'd1;
  assign row_down  = (rem_r + 7'd1 == h_eff) ? 7'd0 : rem_r + 7'd1;

  always_comb begin
    sel_col = rem_c;
    sel_row = rem_r;
    if (cmd.rd_en) begin
      case (cmd.tap)
        TAP_CENTRE: ;
        TAP_LEFT:   sel_col = col_left;
        TAP_RIGHT:  sel_col = col_right;
        TAP_UP:     sel_row = row_up;
        TAP_DOWN:   sel_row = row_down;
        default: ;
      endcase
    end
  end

  assign addr = AW'(int'(sel_row) * MAX_WIDTH + int'(sel_col));

  // Frame store, single port, registered read
  always_ff @(posedge clk) begin
    if (cmd.write_en) begin
      mem[addr] <= pix_hold;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en <= 1'b0;
    end else begin
      acc_en <= cmd.rd_en;
    end
    acc_first <= (cmd.tap == TAP_CENTRE);
  end

  // Per-channel sum: five times the centre, minus each neighbour
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (acc_en) begin
        if (acc_first) begin
          acc[i] <= ($signed({4'b0, rd_data[8*i +: 8]}) <<< 2)
                    + $signed({4'b0, rd_data[8*i +: 8]});
        end else begin
          acc[i] <= acc[i] - $signed({4'b0, rd_data[8*i +: 8]});
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_data.blue_out  <= clamp8(acc[0]);
      out_data.green_out <= clamp8(acc[1]);
      out_data.red_out   <= clamp8(acc[2]);
    end
  end

  assign stat.is_compute = (op_hold == OP_COMPUTE);
  assign stat.out_free   = !out_valid || !out_stall;

endmodule

[rtl/sharpen_3x3_wrap.sv]
// Top level of the 3x3 sharpening block over a three-channel frame store.
// Depends on shp3_pkg, shp3_ctrl and shp3_datapath.
`timescale 1ns / 1ps

// The block holds a MAX_WIDTH x MAX_HEIGHT image of 24-bit pixels (blue in
// bits 7..0, green 15..8, red 23..16) at address row*MAX_WIDTH+column. An
// input transfer with operation load writes one pixel and gives no result;
// with operation compute it returns one result: per channel five times the
// centre minus the left, right, upper and lower neighbours, clamped to
// 0..255, with neighbours wrapping around the image_width x image_height
// area in use. Column and row are first reduced modulo that area by a
// restoring remainder unit. A load then writes its pixel. A compute reads
// five taps one per cycle through the single frame store port, passes a
// drain state and loads the output register once a previous result has
// left it. The input is stalled from the cycle after a transfer until that
// item is done; a finished result sits in the output register while the
// next item is accepted. Size registers: index 0 image_width, index 1
// image_height, each 7 bits, reset 64; 0 acts as 1 and values above the
// maximum act as the maximum. Write them only while the block is idle.
// Pixels never loaded read as undefined; there is no clearing pass.
module sharpen_3x3_wrap
  import shp3_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration writes
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence each transfer: capture, reduce, then write or read taps
  shp3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold sizes, frame store, sums and the result register
  shp3_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
